// ===== design/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the longest prefix route lookup block:
// item layouts, route table entry, sequencer states and operation codes.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // default table size and fixed field widths
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int ADDR_W          = 32;
    localparam int PORT_W          = 2;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // input item
    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] route_prefix_in;
        logic [ADDR_W-1:0] route_mask_in;
        logic [ADDR_W-1:0] route_gateway_in;
        logic [PORT_W-1:0] route_port_in;
        logic [ADDR_W-1:0] destination;
    } in_item_t;

    // result item
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] out_port;
        logic              status;
    } out_item_t;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    // controls from the sequencer to the match unit
    typedef struct packed {
        logic start;        // new lookup: capture destination, clear best
        logic entry_valid;  // table read data holds an entry to compare
    } match_ctrl_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ===== design/lpr_route_ram.sv =====
// ----------------------------------------------------------------------------
// lpr_route_ram
// Route table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpr_route_ram #(
    parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  lpr_pkg::route_entry_t          wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output lpr_pkg::route_entry_t          rd_data
);

    lpr_pkg::route_entry_t mem [TABLE_DEPTH];
    lpr_pkg::route_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lpr_match_unit.sv =====
// ----------------------------------------------------------------------------
// lpr_match_unit
// Shared compare unit: tests one table entry a cycle against the destination
// and keeps the longest matching route seen so far.
// ----------------------------------------------------------------------------
module lpr_match_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpr_pkg::match_ctrl_t  ctrl,
    input  logic [lpr_pkg::ADDR_W-1:0] destination,
    input  lpr_pkg::route_entry_t entry,
    output lpr_pkg::out_item_t    result
);

    logic [lpr_pkg::ADDR_W-1:0] dest_reg;
    logic                       found_reg;
    logic [lpr_pkg::ADDR_W-1:0] best_mask_reg;
    logic [lpr_pkg::ADDR_W-1:0] best_hop_reg;
    logic [lpr_pkg::PORT_W-1:0] best_port_reg;

    logic hit;
    logic better;

    // match and rank: earlier entries win ties, so only a strictly numerically larger mask replaces
    assign hit    = ((dest_reg & entry.mask) == entry.prefix);
    assign better = !found_reg || (entry.mask > best_mask_reg);

    // found flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.start) begin
            found_reg <= 1'b0;
        end else if (ctrl.entry_valid && hit) begin
            found_reg <= 1'b1;
        end
    end

    // destination and best route payload
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            dest_reg      <= destination;
            best_mask_reg <= '0;
            best_hop_reg  <= '0;
            best_port_reg <= '0;
        end else if (ctrl.entry_valid && hit && better) begin
            best_mask_reg <= entry.mask;
            best_hop_reg  <= entry.gateway;
            best_port_reg <= entry.port;
        end
    end

    assign result.found    = found_reg;
    assign result.gateway  = best_hop_reg;
    assign result.out_port = best_port_reg;
    assign result.status   = lpr_pkg::STATUS_OK;

endmodule

// ===== design/longest_prefix_route_lookup.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 route table: loads append routes, lookups return the next hop and
// port of the longest matching prefix, scanning the table one entry a cycle.
// ----------------------------------------------------------------------------
//
//   channel   ports               direction   carries
//   input     s_valid/s_ready     in          in_item_t  (load or lookup)
//   result    m_valid/m_ready     out         out_item_t (one per item)
//
// A load moves from ST_IDLE to ST_RESULT, where its result is registered into
// the output register once it is free; the next item is accepted back in ST_IDLE.
// A lookup scans the stored entries in ST_SCAN, paced by the single table read
// port feeding the shared compare unit one entry per cycle, plus the registered read.
// Reset empties the table by clearing the entry count; no clearing pass.
// The output register holds a result while m_ready is low; the next item is
// accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup #(
    parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lpr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lpr_pkg::out_item_t m_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    lpr_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               rd_valid_reg;
    logic               op_reg;
    logic               full_reg;
    logic               m_valid_reg;
    lpr_pkg::out_item_t m_data_reg;

    logic                  accept;
    logic                  table_full;
    logic                  wr_en;
    logic                  scan_rd_en;
    logic                  out_load;
    lpr_pkg::route_entry_t wr_entry;
    lpr_pkg::route_entry_t rd_entry;
    lpr_pkg::match_ctrl_t  match_ctrl;
    lpr_pkg::out_item_t    match_result;
    lpr_pkg::out_item_t    load_result;

    assign accept     = s_valid && s_ready;
    assign table_full = (entry_count_reg == DEPTH_CNT);
    assign wr_en      = accept && (s_data.operation == lpr_pkg::OP_LOAD) && !table_full;

    // sequencer next state and strobes
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        scan_rd_en = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            lpr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.operation == lpr_pkg::OP_LOOKUP) begin
                        state_next = lpr_pkg::ST_SCAN;
                    end else begin
                        state_next = lpr_pkg::ST_RESULT;
                    end
                end
            end
            lpr_pkg::ST_SCAN: begin
                scan_rd_en = (scan_idx_reg < entry_count_reg);
                if (!scan_rd_en && !rd_valid_reg) begin
                    state_next = lpr_pkg::ST_RESULT;
                end
            end
            lpr_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // entry count, scan index and read pipeline valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
        end else begin
            rd_valid_reg <= scan_rd_en;
            if (wr_en) begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end
            if (accept) begin
                scan_idx_reg <= '0;
            end else if (scan_rd_en) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
        end
    end

    // item bookkeeping
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_data.operation;
            full_reg <= table_full;
        end
    end

    // route table
    assign wr_entry.prefix  = s_data.route_prefix_in;
    assign wr_entry.mask    = s_data.route_mask_in;
    assign wr_entry.gateway = s_data.route_gateway_in;
    assign wr_entry.port    = s_data.route_port_in;

    lpr_route_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (entry_count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // compare unit
    assign match_ctrl.start       = accept && (s_data.operation == lpr_pkg::OP_LOOKUP);
    assign match_ctrl.entry_valid = rd_valid_reg;

    lpr_match_unit u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (match_ctrl),
        .destination (s_data.destination),
        .entry       (rd_entry),
        .result      (match_result)
    );

    // load result
    assign load_result.found    = 1'b0;
    assign load_result.gateway  = '0;
    assign load_result.out_port = '0;
    assign load_result.status   = full_reg ? lpr_pkg::STATUS_FULL : lpr_pkg::STATUS_OK;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= (op_reg == lpr_pkg::OP_LOOKUP) ? match_result : load_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: longest prefix route lookup testbench
// Feeds load and lookup items through the input channel with random gaps,
// predicts each result from a local copy of the route table, and checks
// every result field by field against the oldest prediction. The table is
// filled past capacity during the run, so refused loads and full-table scans
// are covered along with misses, ties and nested prefixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH      = lpr_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_N   = 1130;
    localparam int BASE_COUNT = 6;

    // one queued request: the item and whether the sender drains first
    typedef struct {
        lpr_pkg::in_item_t item;
        bit                drain_first;
    } request_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    lpr_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    lpr_pkg::out_item_t m_data;

    request_t           queued_requests[$];
    lpr_pkg::out_item_t awaited_results[$];
    int                 mismatch_count = 0;

    // local route table
    lpr_pkg::route_entry_t route_table[DEPTH];
    int unsigned           route_count = 0;

    // routes generated so far, used to aim lookups at stored prefixes
    lpr_pkg::route_entry_t issued_routes[$];
    logic [31:0]           base_pool[BASE_COUNT];

    // driver and monitor working state
    logic               drive_valid;
    request_t           next_request;
    int                 send_gap   = 0;
    bit                 send_quiet = 1'b0;
    logic               take_ready;
    lpr_pkg::out_item_t want;
    int                 recv_stall = 0;
    bit                 recv_quiet = 1'b0;

    longest_prefix_route_lookup u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result of one item, updating the local table on a load
    function automatic lpr_pkg::out_item_t next_route_result(lpr_pkg::in_item_t it);
        lpr_pkg::out_item_t res;
        logic [31:0]        best_mask;
        int                 i;
        res       = '0;
        best_mask = '0;
        res.status = lpr_pkg::STATUS_OK;
        if (it.operation == lpr_pkg::OP_LOAD) begin
            if (route_count >= DEPTH) begin
                res.status = lpr_pkg::STATUS_FULL;
            end else begin
                route_table[route_count] = '{it.route_prefix_in, it.route_mask_in,
                                             it.route_gateway_in, it.route_port_in};
                route_count++;
            end
        end else begin
            for (i = 0; i < route_count; i++) begin
                if ((it.destination & route_table[i].mask) == route_table[i].prefix &&
                    (!res.found || route_table[i].mask > best_mask)) begin
                    res.found    = 1'b1;
                    best_mask    = route_table[i].mask;
                    res.gateway  = route_table[i].gateway;
                    res.out_port = route_table[i].port;
                end
            end
        end
        return res;
    endfunction

    task automatic add_load(input logic [31:0] prefix, input logic [31:0] mask,
                            input logic [31:0] hop, input logic [1:0] port,
                            input bit drain);
        request_t              r;
        lpr_pkg::route_entry_t route;
        r.item.operation        = lpr_pkg::OP_LOAD;
        r.item.route_prefix_in  = prefix;
        r.item.route_mask_in    = mask;
        r.item.route_gateway_in = hop;
        r.item.route_port_in    = port;
        r.item.destination      = $urandom;
        r.drain_first           = drain;
        queued_requests = {queued_requests, r};
        route.prefix  = prefix;
        route.mask    = mask;
        route.gateway = hop;
        route.port    = port;
        if (issued_routes.size() < DEPTH)
            issued_routes = {issued_routes, route};
    endtask

    task automatic add_lookup(input logic [31:0] dest, input bit drain);
        request_t r;
        r.item.operation        = lpr_pkg::OP_LOOKUP;
        r.item.route_prefix_in  = $urandom;
        r.item.route_mask_in    = $urandom;
        r.item.route_gateway_in = $urandom;
        r.item.route_port_in    = 2'($urandom_range(0, 3));
        r.item.destination      = dest;
        r.drain_first           = drain;
        queued_requests = {queued_requests, r};
    endtask

    // stimulus and end of run
    initial begin
        int          n;
        int          len;
        int          pick;
        logic [31:0] mask_bits;
        logic [31:0] base;
        bit          drain;

        // empty table: must miss
        add_lookup(32'hFFFF_FFFF, 1'b0);

        // host route, nested prefixes, a tie, odd masks
        add_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 2'd0, 1'b0);
        add_load(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 2'd1, 1'b0);
        add_load(32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_0201, 2'd2, 1'b0);
        add_load(32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 2'd3, 1'b0);
        add_load(32'h00FF_00FF, 32'h00FF_00FF, 32'h5555_AAAA, 2'd2, 1'b0);
        add_load(32'h0B00_00FF, 32'hFF00_0000, 32'hDEAD_0001, 2'd1, 1'b0);
        add_load(32'h1234_5678, 32'h0000_0000, 32'hBEEF_0002, 2'd3, 1'b0);
        add_load(32'hC0A8_0000, 32'hFFFF_0000, 32'h0000_0000, 2'd0, 1'b0);

        add_lookup(32'hFFFF_FFFF, 1'b1);
        add_lookup(32'h0000_0000, 1'b0);
        add_lookup(32'h0A01_02FF, 1'b0);
        add_lookup(32'h0A7F_0000, 1'b0);
        add_lookup(32'h0B00_00FF, 1'b0);
        add_lookup(32'hAAFF_BBFF, 1'b0);
        add_lookup(32'hC0A8_1234, 1'b0);
        add_lookup(32'h1234_5678, 1'b0);

        // a few shared bases so random routes nest and tie
        for (n = 0; n < BASE_COUNT; n++)
            base_pool[n] = $urandom;

        for (n = 0; n < RANDOM_N; n++) begin
            drain = (n % 200 == 0);
            if ($urandom_range(0, 99) < 40) begin
                if (issued_routes.size() == DEPTH - 16) begin
                    // default route late in the fill, so misses stay common before it
                    add_load(32'h0, 32'h0, $urandom, 2'($urandom_range(0, 3)), drain);
                end else begin
                    pick = $urandom_range(0, 99);
                    len  = $urandom_range(1, 32);
                    mask_bits = 32'hFFFF_FFFF << (32 - len);
                    if (pick < 10)
                        add_load($urandom, $urandom, $urandom,
                                 2'($urandom_range(0, 3)), drain);
                    else if (pick < 25)
                        add_load($urandom & mask_bits, mask_bits, $urandom,
                                 2'($urandom_range(0, 3)), drain);
                    else
                        add_load(base_pool[$urandom_range(0, BASE_COUNT - 1)] & mask_bits,
                                 mask_bits, $urandom, 2'($urandom_range(0, 3)), drain);
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && issued_routes.size() > 0) begin
                    // aim at a stored route, random bits outside its mask
                    len = $urandom_range(0, issued_routes.size() - 1);
                    add_lookup(issued_routes[len].prefix |
                               ($urandom & ~issued_routes[len].mask), drain);
                end else if (pick < 85) begin
                    base = base_pool[$urandom_range(0, BASE_COUNT - 1)];
                    len  = $urandom_range(0, 32);
                    mask_bits = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
                    add_lookup((base & mask_bits) | ($urandom & ~mask_bits), drain);
                end else begin
                    add_lookup($urandom, drain);
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for all items to go in and all results to come back
        @(negedge aclk);
        while (queued_requests.size() > 0 || s_valid || awaited_results.size() > 0)
            @(negedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // driver: presents queued items with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            send_gap = 0;
        end else begin
            drive_valid = s_valid;
            if (s_valid && s_ready) begin
                awaited_results = {awaited_results, next_route_result(s_data)};
                drive_valid = 1'b0;
            end
            if (!drive_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_requests.size() > 0 &&
                             !(queued_requests[0].drain_first &&
                               awaited_results.size() > 0)) begin
                    next_request = queued_requests.pop_front();
                    s_data <= next_request.item;
                    drive_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = !send_quiet;
                    send_gap = send_quiet ? 0 : $urandom_range(0, 14);
                end
            end
            s_valid <= drive_valid;
        end
    end

    // monitor: random stalls on the result side, field checks
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            take_ready = m_ready;
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.found !== want.found) begin
                        $display("%0t: found expected %b actual %b",
                                 $time, want.found, m_data.found);
                        mismatch_count++;
                    end
                    if (m_data.gateway !== want.gateway) begin
                        $display("%0t: gateway expected %h actual %h",
                                 $time, want.gateway, m_data.gateway);
                        mismatch_count++;
                    end
                    if (m_data.out_port !== want.out_port) begin
                        $display("%0t: out_port expected %0d actual %0d",
                                 $time, want.out_port, m_data.out_port);
                        mismatch_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $time, want.status, m_data.status);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = !recv_quiet;
                recv_stall = recv_quiet ? 0 : $urandom_range(0, 14);
                take_ready = (recv_stall == 0);
            end else if (!m_ready) begin
                if (recv_stall > 0)
                    recv_stall--;
                take_ready = (recv_stall == 0);
            end
            m_ready <= take_ready;
        end
    end

endmodule
